/* design/bnpm_pkg.sv */
package bnpm_pkg;

    localparam int NODES        = 8;
    localparam int NODE_W       = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int MAX_ID_BYTES = 8;
    localparam int ID_LEN_W     = 4;

    localparam logic [7:0] MSG_STATUS_RESP = 8'h02;
    localparam logic [7:0] MSG_UPDATE_RESP = 8'h04;

    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [7:0]  NETWORK_RESET = 8'h01;
    localparam logic [7:0]  ADDRESS_RESET = 8'hFF;

    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_NETWORK = 2'd1;
    localparam logic [1:0] REG_ADDRESS = 2'd2;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_RUN      = 3'd1,
        ACT_HOST_UPD = 3'd2,
        ACT_QUERY    = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        KIND_NONE       = 3'd0,
        KIND_STATUS_REQ = 3'd1,
        KIND_UPDATE_REQ = 3'd2,
        KIND_UPDATE_RES = 3'd3,
        KIND_QUERY      = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE        = 2'd0,
        ST_WAIT_STATUS = 2'd1,
        ST_WAIT_UPDATE = 2'd2
    } t_state;

    typedef struct packed {
        logic [ID_LEN_W-1:0] len;
        logic [63:0]         id;
        logic [7:0]          code;
        logic [7:0]          ctype;
        logic [7:0]          used;
    } t_card;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  node;
        logic        ok;
        logic        det;
        logic [7:0]  err;
        t_card       card;
        logic        last;
    } t_res;

    typedef struct packed {
        logic              load;
        logic              shift;
        logic              run;
        logic              send_status;
        logic              send_update;
        logic              clr_status;
        logic              clr_update;
        logic              host_upd;
        logic              query;
        logic              clear;
        logic [NODE_W-1:0] cur;
    } t_cmd;

    typedef struct packed {
        logic [NODES-1:0] waiting;
        logic [NODES-1:0] status_seen;
        logic [NODES-1:0] update_seen;
        logic             upd_frame;
    } t_sts;

    function automatic t_card take_card(input logic [7:0] len, input logic [63:0] id,
                                        input logic [7:0] code, input logic [7:0] ctype,
                                        input logic [7:0] used);
        t_card c;
        c.len = (len > 8'(MAX_ID_BYTES)) ? ID_LEN_W'(MAX_ID_BYTES) : len[ID_LEN_W-1:0];
        for (int b = 0; b < 8; b++) begin
            c.id[8*b +: 8] = (ID_LEN_W'(b) < c.len) ? id[8*b +: 8] : 8'h00;
        end
        c.code  = code;
        c.ctype = ctype;
        c.used  = used;
        return c;
    endfunction

endpackage

/* design/bnpm_regs.sv */
module bnpm_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_timeout_ticks,
    output logic [7:0]  o_bus_network,
    output logic [7:0]  o_master_address
);

    logic [15:0] r_timeout;
    logic [7:0]  r_network;
    logic [7:0]  r_address;
    logic        wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= bnpm_pkg::TIMEOUT_RESET;
            r_network <= bnpm_pkg::NETWORK_RESET;
            r_address <= bnpm_pkg::ADDRESS_RESET;
        end else if (wr) begin
            unique case (paddr[3:2])
                bnpm_pkg::REG_TIMEOUT: r_timeout <= pwdata[15:0];
                bnpm_pkg::REG_NETWORK: r_network <= pwdata[7:0];
                bnpm_pkg::REG_ADDRESS: r_address <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bnpm_pkg::REG_TIMEOUT: prdata = {16'h0000, r_timeout};
            bnpm_pkg::REG_NETWORK: prdata = {24'h000000, r_network};
            bnpm_pkg::REG_ADDRESS: prdata = {24'h000000, r_address};
            default:               prdata = 32'h0000_0000;
        endcase
    end

    assign o_timeout_ticks  = r_timeout;
    assign o_bus_network    = r_network;
    assign o_master_address = r_address;

endmodule

/* design/bnpm_ctrl.sv */
module bnpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_action,
    input  logic              i_stall,
    input  logic [15:0]       i_timeout_ticks,
    input  bnpm_pkg::t_sts    i_sts,
    output logic              o_stall,
    output logic              o_valid,
    output bnpm_pkg::t_cmd    o_cmd
);

    bnpm_pkg::t_state               r_state, n_state;
    logic [bnpm_pkg::NODE_W-1:0]    r_cur, n_cur;
    logic [15:0]                    r_tcount, n_tcount;
    logic                           r_tout, n_tout;
    logic [1:0]                     r_cnt, n_cnt;
    logic                           acc;
    logic                           out_acc;
    logic                           arm;
    logic                           adv;
    logic                           tick;
    logic [1:0]                     res_n;

    assign o_stall = (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign acc     = i_valid & ~o_stall;
    assign out_acc = o_valid & ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bnpm_pkg::ST_IDLE;
            r_cur    <= '0;
            r_tcount <= '0;
            r_tout   <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_tcount <= n_tcount;
            r_tout   <= n_tout;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.cur    = r_cur;
        o_cmd.load   = acc;
        o_cmd.shift  = out_acc;
        n_state      = r_state;
        arm          = 1'b0;
        adv          = 1'b0;
        tick         = 1'b0;

        if (acc) begin
            unique case (bnpm_pkg::t_action'(i_action))
                bnpm_pkg::ACT_TICK:     tick = 1'b1;
                bnpm_pkg::ACT_HOST_UPD: o_cmd.host_upd = 1'b1;
                bnpm_pkg::ACT_QUERY:    o_cmd.query = 1'b1;
                bnpm_pkg::ACT_CLEAR:    o_cmd.clear = 1'b1;
                bnpm_pkg::ACT_RUN: begin
                    o_cmd.run = 1'b1;
                    unique case (r_state)
                        bnpm_pkg::ST_IDLE: begin
                            arm = 1'b1;
                            if (i_sts.waiting[r_cur]) begin
                                o_cmd.send_update = 1'b1;
                                n_state = bnpm_pkg::ST_WAIT_UPDATE;
                            end else begin
                                o_cmd.send_status = 1'b1;
                                n_state = bnpm_pkg::ST_WAIT_STATUS;
                            end
                        end
                        bnpm_pkg::ST_WAIT_STATUS: begin
                            if (i_sts.status_seen[r_cur]) begin
                                o_cmd.clr_status = 1'b1;
                                n_state = bnpm_pkg::ST_IDLE;
                                adv = 1'b1;
                            end else if (r_tout) begin
                                n_state = bnpm_pkg::ST_IDLE;
                                adv = 1'b1;
                            end
                        end
                        bnpm_pkg::ST_WAIT_UPDATE: begin
                            if (i_sts.update_seen[r_cur]) begin
                                o_cmd.clr_update = 1'b1;
                                n_state = bnpm_pkg::ST_IDLE;
                                adv = 1'b1;
                            end else if (r_tout) begin
                                n_state = bnpm_pkg::ST_IDLE;
                            end
                        end
                        default: n_state = bnpm_pkg::ST_IDLE;
                    endcase
                end
                default: ;
            endcase
        end

        res_n = o_cmd.query ? 2'd1
                            : 2'(o_cmd.send_status | o_cmd.send_update)
                              + 2'(o_cmd.run & i_sts.upd_frame);

        n_cur = r_cur;
        if (adv) begin
            n_cur = (r_cur == bnpm_pkg::NODE_W'(bnpm_pkg::NODES - 1)) ? '0
                                                                       : r_cur + 1'b1;
        end

        n_tcount = r_tcount;
        n_tout   = r_tout;
        if (arm) begin
            n_tcount = i_timeout_ticks;
            n_tout   = 1'b0;
        end else if (tick && r_tcount != 16'd0) begin
            n_tcount = r_tcount - 16'd1;
            if (r_tcount == 16'd1) begin
                n_tout = 1'b1;
            end
        end

        n_cnt = r_cnt;
        if (acc) begin
            n_cnt = res_n;
        end else if (out_acc) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

endmodule

/* design/bnpm_dp.sv */
module bnpm_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bnpm_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_bus_network,
    input  logic [7:0]      i_master_address,
    input  logic            i_frame_present,
    input  logic [7:0]      i_network_id,
    input  logic [7:0]      i_dest_node,
    input  logic [7:0]      i_node,
    input  logic [7:0]      i_message_kind,
    input  logic            i_result_ok,
    input  logic [7:0]      i_card_id_len,
    input  logic [63:0]     i_card_id,
    input  logic [7:0]      i_card_code,
    input  logic [7:0]      i_card_type,
    input  logic [7:0]      i_card_used,
    output bnpm_pkg::t_sts  o_sts,
    output bnpm_pkg::t_res  o_res
);

    localparam int N  = bnpm_pkg::NODES;
    localparam int NW = bnpm_pkg::NODE_W;

    logic [N-1:0]    r_placed, n_placed;
    logic [N-1:0]    r_detected, n_detected;
    logic [N-1:0]    r_status_seen, n_status_seen;
    logic [N-1:0]    r_update_seen, n_update_seen;
    logic [N-1:0]    r_waiting, n_waiting;
    logic [N-1:0]    r_store_vld;
    bnpm_pkg::t_card r_store [N];
    bnpm_pkg::t_card r_pending [N];
    bnpm_pkg::t_res  r_slot0, r_slot1;

    bnpm_pkg::t_card in_card;
    bnpm_pkg::t_res  res_req, res_upd, res_q, n_slot0, n_slot1;
    logic [NW-1:0]   idx;
    logic            node_ok;
    logic            frame_hit;
    logic            frame_ok;
    logic            st_resp;
    logic            up_resp;
    logic            emit_req;
    logic [1:0]      n_res;

    assign in_card   = bnpm_pkg::take_card(i_card_id_len, i_card_id, i_card_code,
                                           i_card_type, i_card_used);
    assign idx       = i_node[NW-1:0];
    assign node_ok   = (i_node < 8'(N));
    assign frame_hit = i_frame_present & (i_network_id == i_bus_network)
                     & (i_dest_node == i_master_address) & node_ok;
    assign frame_ok  = i_cmd.run & frame_hit;
    assign st_resp   = frame_ok & (i_message_kind == bnpm_pkg::MSG_STATUS_RESP);
    assign up_resp   = frame_ok & (i_message_kind == bnpm_pkg::MSG_UPDATE_RESP);
    assign emit_req  = i_cmd.send_status | i_cmd.send_update;
    assign n_res     = i_cmd.query ? 2'd1 : (2'(emit_req) + 2'(up_resp));

    assign o_sts.waiting     = r_waiting;
    assign o_sts.status_seen = r_status_seen;
    assign o_sts.update_seen = r_update_seen;
    assign o_sts.upd_frame   = frame_hit & (i_message_kind == bnpm_pkg::MSG_UPDATE_RESP);

    always_comb begin
        res_req      = '0;
        res_req.kind = i_cmd.send_update ? bnpm_pkg::KIND_UPDATE_REQ
                                         : bnpm_pkg::KIND_STATUS_REQ;
        res_req.node = 8'(i_cmd.cur);
        if (i_cmd.send_update) begin
            res_req.card = r_pending[i_cmd.cur];
        end

        res_upd      = '0;
        res_upd.kind = bnpm_pkg::KIND_UPDATE_RES;
        res_upd.node = i_node;
        res_upd.ok   = (i_card_id_len == 8'h00);
        res_upd.err  = i_card_id_len;
        res_upd.last = 1'b1;

        res_q      = '0;
        res_q.kind = bnpm_pkg::KIND_QUERY;
        res_q.node = i_node;
        if (node_ok) begin
            res_q.ok  = r_placed[idx];
            res_q.det = r_detected[idx];
            if (r_store_vld[idx]) begin
                res_q.card = r_store[idx];
            end
        end

        priority if (i_cmd.query) begin
            n_slot0 = res_q;
        end else if (emit_req) begin
            n_slot0 = res_req;
        end else begin
            n_slot0 = res_upd;
        end
        n_slot0.last = (n_res == 2'd1);
        n_slot1      = res_upd;

        n_placed      = r_placed;
        n_detected    = r_detected;
        n_status_seen = r_status_seen;
        n_update_seen = r_update_seen;
        n_waiting     = r_waiting;

        if (i_cmd.clr_status) n_status_seen[i_cmd.cur] = 1'b0;
        if (i_cmd.clr_update) n_update_seen[i_cmd.cur] = 1'b0;
        if (i_cmd.send_update) n_waiting[i_cmd.cur] = 1'b0;
        if (i_cmd.host_upd && node_ok) n_waiting[idx] = 1'b1;
        if (i_cmd.clear && node_ok) n_detected[idx] = 1'b0;
        if (st_resp) begin
            n_status_seen[idx] = 1'b1;
            if (i_result_ok) begin
                if (!r_placed[idx]) n_detected[idx] = 1'b1;
                n_placed[idx] = 1'b1;
            end else begin
                n_placed[idx] = 1'b0;
            end
        end
        if (up_resp) n_update_seen[idx] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed      <= '0;
            r_detected    <= '0;
            r_status_seen <= '0;
            r_update_seen <= '0;
            r_waiting     <= '0;
            r_store_vld   <= '0;
        end else begin
            r_placed      <= n_placed;
            r_detected    <= n_detected;
            r_status_seen <= n_status_seen;
            r_update_seen <= n_update_seen;
            r_waiting     <= n_waiting;
            if (st_resp && i_result_ok) begin
                r_store_vld[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_resp && i_result_ok) begin
            r_store[idx] <= in_card;
        end
        if (i_cmd.host_upd && node_ok) begin
            r_pending[idx] <= in_card;
        end
        if (i_cmd.load) begin
            r_slot0 <= n_slot0;
            r_slot1 <= n_slot1;
        end else if (i_cmd.shift) begin
            r_slot0 <= r_slot1;
        end
    end

    assign o_res = r_slot0;

endmodule

/* design/bus_node_polling_master_top.sv */
// Round-robin polling master for card-reader nodes. An input word is taken and its zero to
// two result words are queued in a two-entry output register; one result word leaves per
// cycle while i_stall is low, and the input side stalls until the results of the previous
// word are all taken. Card data,
// placed and newly-detected marks per node are read with a status query. Registers
// (APB, byte address): 0x0 timeout in ticks, 0x4 network number, 0x8 master address.
module bus_node_polling_master_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic        i_frame_present,
    input  logic [7:0]  i_network_id,
    input  logic [7:0]  i_dest_node,
    input  logic [7:0]  i_node,
    input  logic [7:0]  i_message_kind,
    input  logic        i_result_ok,
    input  logic [7:0]  i_card_id_len,
    input  logic [63:0] i_card_id,
    input  logic [7:0]  i_card_code,
    input  logic [7:0]  i_card_type,
    input  logic [7:0]  i_card_used,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_out_kind,
    output logic [7:0]  o_out_node,
    output logic        o_out_ok,
    output logic        o_out_detected,
    output logic [7:0]  o_out_error,
    output logic [3:0]  o_out_card_id_len,
    output logic [63:0] o_out_card_id,
    output logic [7:0]  o_out_card_code,
    output logic [7:0]  o_out_card_type,
    output logic [7:0]  o_out_card_used,
    output logic        o_last
);

    logic [15:0]    timeout_ticks;
    logic [7:0]     bus_network;
    logic [7:0]     master_address;
    bnpm_pkg::t_cmd cmd;
    bnpm_pkg::t_sts sts;
    bnpm_pkg::t_res res;

    bnpm_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_timeout_ticks  (timeout_ticks),
        .o_bus_network    (bus_network),
        .o_master_address (master_address)
    );

    bnpm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_action        (i_action),
        .i_stall         (i_stall),
        .i_timeout_ticks (timeout_ticks),
        .i_sts           (sts),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .o_cmd           (cmd)
    );

    bnpm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_bus_network    (bus_network),
        .i_master_address (master_address),
        .i_frame_present  (i_frame_present),
        .i_network_id     (i_network_id),
        .i_dest_node      (i_dest_node),
        .i_node           (i_node),
        .i_message_kind   (i_message_kind),
        .i_result_ok      (i_result_ok),
        .i_card_id_len    (i_card_id_len),
        .i_card_id        (i_card_id),
        .i_card_code      (i_card_code),
        .i_card_type      (i_card_type),
        .i_card_used      (i_card_used),
        .o_sts            (sts),
        .o_res            (res)
    );

    assign o_out_kind        = res.kind;
    assign o_out_node        = res.node;
    assign o_out_ok          = res.ok;
    assign o_out_detected    = res.det;
    assign o_out_error       = res.err;
    assign o_out_card_id_len = res.card.len;
    assign o_out_card_id     = res.card.id;
    assign o_out_card_code   = res.card.code;
    assign o_out_card_type   = res.card.ctype;
    assign o_out_card_used   = res.card.used;
    assign o_last            = res.last;

endmodule
